// File: rtl/core/nsrc_pkg.sv
`default_nettype none

package nsrc_pkg;

	// fixed field widths
	localparam int RATE_W      = 18;
	localparam int SAMPLE_W    = 16;
	localparam int CHANNEL_W   = 16;
	localparam int DATA_W      = 32;
	localparam int REG_ADDR_W  = 4;
	localparam int MUL_CHUNK_W = 32;

	// defaults for the top level parameters
	localparam int DEF_MAX_OUTPUTS = 8;
	localparam int DEF_INDEX_BITS  = 48;
	localparam int DEF_QUEUE_DEPTH = 2;

	// register reset values
	localparam logic [RATE_W-1:0] RST_SOURCE_RATE = 18'd44100;
	localparam logic [RATE_W-1:0] RST_TARGET_RATE = 18'd16000;
	localparam logic              RST_SIXTEEN_BIT = 1'b1;
	localparam logic              RST_AVERAGE     = 1'b0;

	// register indexes, byte address 4*index
	typedef enum logic [1:0] {
		REG_SOURCE_RATE = 2'd0,
		REG_TARGET_RATE = 2'd1,
		REG_SIXTEEN_BIT = 2'd2,
		REG_AVERAGE     = 2'd3
	} reg_idx_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// effective configuration, rates already forced non-zero
	typedef struct packed {
		logic [RATE_W-1:0] src_rate;
		logic [RATE_W-1:0] tgt_rate;
		logic              sixteen_bit;
		logic              average;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/nsrc_if.sv
`default_nettype none

// frame request channel
interface nsrc_frame_if import nsrc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHANNEL_W-1:0] channel_a;
	logic [CHANNEL_W-1:0] channel_b;

	modport source (output valid, output channel_a, output channel_b, input ready);
	modport sink (input valid, input channel_a, input channel_b, output ready);
endinterface

// result request channel
interface nsrc_result_if import nsrc_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last;
	logic    truncated;

	modport source (output valid, output sample, output last, output truncated, input ready);
	modport sink (input valid, input sample, input last, input truncated, output ready);
endinterface

`default_nettype wire

// File: rtl/core/nsrc_front.sv
`default_nettype none

module nsrc_front import nsrc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	nsrc_frame_if.sink   frames,
	output logic         push_valid,
	input  wire logic    push_ready,
	output sample_t      push_sample
);

	logic    vld_s1;
	sample_t smp_s1;

	// sample format conversion, average truncated toward zero
	function automatic sample_t make_sample(input logic [CHANNEL_W-1:0] a,
		input logic [CHANNEL_W-1:0] b, input cfg_t c);
		logic [16:0] sum16;
		logic [16:0] adj16;
		logic [8:0]  sum8;
		logic [15:0] res;
		sum16 = {a[15], a} + {b[15], b};
		adj16 = sum16 + {16'd0, sum16[16]};
		sum8  = {a[7], a[7:0]} + {b[7], b[7:0]};
		if (c.sixteen_bit) begin
			res = c.average ? adj16[16:1] : a;
		end else begin
			res = c.average ? {sum8, 7'd0} : {a[7:0], 8'd0};
		end
		return sample_t'(res);
	endfunction

	assign frames.ready = !vld_s1 || push_ready;

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (frames.valid && frames.ready) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// converted sample
	always_ff @(posedge clk) begin
		if (frames.valid && frames.ready) begin
			smp_s1 <= make_sample(frames.channel_a, frames.channel_b, cfg);
		end
	end

	assign push_valid  = vld_s1;
	assign push_sample = smp_s1;

endmodule

`default_nettype wire

// File: rtl/core/nsrc_queue.sv
`default_nettype none

module nsrc_queue import nsrc_pkg::*; #(
	parameter int WIDTH = SAMPLE_W,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/nsrc_div.sv
`default_nettype none

module nsrc_div import nsrc_pkg::*; #(
	parameter int NUM_W = DEF_INDEX_BITS + RATE_W + 2,
	parameter int DEN_W = RATE_W + 1,
	parameter int QUO_W = DEF_INDEX_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [QUO_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// one restoring step: shift in the next numerator bit
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, only the low quotient bits are kept
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= DEN_W'(ge ? rem_sh - {1'b0, den} : rem_sh);
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

// File: rtl/core/nsrc_back.sv
`default_nettype none

module nsrc_back import nsrc_pkg::*; #(
	parameter int MAX_OUTPUTS_PER_FRAME = DEF_MAX_OUTPUTS,
	parameter int INDEX_BITS            = DEF_INDEX_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     job_valid,
	output logic          job_ready,
	input  wire sample_t  job_sample,
	nsrc_result_if.source results
);

	localparam int OPND_W = INDEX_BITS + 1;
	localparam int NCH    = (OPND_W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
	localparam int PAD_W  = NCH * MUL_CHUNK_W;
	localparam int PP_W   = MUL_CHUNK_W + RATE_W;
	localparam int PROD_W = INDEX_BITS + 1 + RATE_W;
	localparam int NUM_W  = PROD_W + 1;
	localparam int S2_W   = RATE_W + 1;
	localparam int MCNT_W = $clog2(NCH + 1);
	localparam int CNT_W  = $clog2(MAX_OUTPUTS_PER_FRAME + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_COUNT = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [INDEX_BITS-1:0]   f_q;
	logic [INDEX_BITS-1:0]   k_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        e_q;
	logic [MCNT_W-1:0]       mcnt_q;
	logic                    trunc_q;
	sample_t                 sample_q;
	logic [PAD_W-1:0]        opl_q;
	logic [PAD_W-1:0]        opp_q;
	logic [PP_W-1:0]         ppl_s1;
	logic [PP_W-1:0]         ppp_s1;
	logic [PROD_W-1:0]       accl_q;
	logic [PROD_W-1:0]       accp_q;
	logic [S2_W-1:0]         s2;
	logic [S2_W-1:0]         s2m1;
	logic                    due;
	logic                    full;
	logic                    last;
	logic                    div_start;
	logic                    div_done;
	logic [INDEX_BITS-1:0]   div_quot;
	logic [NUM_W-1:0]        div_num;

	assign s2   = {cfg.src_rate, 1'b0};
	assign s2m1 = s2 - S2_W'(1);

	// output k is due while k*2S stays below (2f+1)*T
	assign due  = accp_q < accl_q;
	assign full = n_q == CNT_W'(MAX_OUTPUTS_PER_FRAME);
	assign last = (e_q + CNT_W'(1)) == n_q;

	assign div_start = (state_q == ST_COUNT) && due && full;
	assign div_num   = NUM_W'(accl_q) + NUM_W'(s2m1);

	assign job_ready         = state_q == ST_IDLE;
	assign results.valid     = state_q == ST_EMIT;
	assign results.sample    = sample_q;
	assign results.last      = last;
	assign results.truncated = trunc_q;

	// first output due after the current frame when the burst is cut short
	nsrc_div #(
		.NUM_W (NUM_W),
		.DEN_W (S2_W),
		.QUO_W (INDEX_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s2),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer and index state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			f_q     <= '0;
			k_q     <= '0;
			n_q     <= '0;
			e_q     <= '0;
			mcnt_q  <= '0;
			trunc_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						n_q     <= '0;
						e_q     <= '0;
						mcnt_q  <= '0;
						trunc_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					mcnt_q <= mcnt_q + MCNT_W'(1);
					if (mcnt_q == MCNT_W'(NCH)) begin
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					if (!due) begin
						if (n_q == '0) begin
							f_q     <= f_q + INDEX_BITS'(1);
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT;
						end
					end else if (full) begin
						trunc_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						n_q <= n_q + CNT_W'(1);
						k_q <= k_q + INDEX_BITS'(1);
					end
				end
				ST_DIV: begin
					if (div_done) begin
						k_q     <= div_quot;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (results.ready) begin
						e_q <= e_q + CNT_W'(1);
						if (last) begin
							f_q     <= f_q + INDEX_BITS'(1);
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// products by 32-bit partial products, top chunk first
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					sample_q <= job_sample;
					opl_q    <= PAD_W'({f_q, 1'b1});
					opp_q    <= PAD_W'({k_q, 1'b0});
					accl_q   <= '0;
					accp_q   <= '0;
				end
			end
			ST_MUL: begin
				if (mcnt_q < MCNT_W'(NCH)) begin
					ppl_s1 <= PP_W'(opl_q[PAD_W-1 -: MUL_CHUNK_W]) * PP_W'(cfg.tgt_rate);
					ppp_s1 <= PP_W'(opp_q[PAD_W-1 -: MUL_CHUNK_W]) * PP_W'(cfg.src_rate);
					opl_q  <= opl_q << MUL_CHUNK_W;
					opp_q  <= opp_q << MUL_CHUNK_W;
				end
				if (mcnt_q != '0) begin
					accl_q <= (accl_q << MUL_CHUNK_W) + PROD_W'(ppl_s1);
					accp_q <= (accp_q << MUL_CHUNK_W) + PROD_W'(ppp_s1);
				end
			end
			ST_COUNT: begin
				// stepping k by one adds 2S, wrapping k restarts at zero
				if (due && !full) begin
					accp_q <= (k_q == '1) ? '0 : accp_q + PROD_W'(s2);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_trunc_full: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.truncated |-> full)
		else $error("truncated result without a full burst");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && last |=> state_q == ST_IDLE)
		else $error("sequencer not idle after last result");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> (e_q < n_q))
		else $error("more results than counted");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");
	a_job_mul: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> state_q == ST_MUL && mcnt_q == '0)
		else $error("accepted frame did not start the products");
`endif

endmodule

`default_nettype wire

// File: rtl/core/nearest_sample_rate_converter_unit.sv
// flow: a frame passes the front end register and the queue before it reaches the back end,
// which forms the products in 32-bit chunks, then runs the due count and emits the results,
// one a cycle while the receiver is ready; the back end takes a new frame only in its
// idle state, after the last one; a truncated frame also runs the bit-serial divider
// reset: arst_n clears both indices, the queue and all handshakes at once and loads the
// register defaults
`default_nettype none

module nearest_sample_rate_converter_unit import nsrc_pkg::*; #(
	parameter int MAX_OUTPUTS_PER_FRAME = DEF_MAX_OUTPUTS,
	parameter int INDEX_BITS            = DEF_INDEX_BITS,
	parameter int QUEUE_DEPTH           = DEF_QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	nsrc_frame_if.sink                 frames,
	nsrc_result_if.source              results
);

	logic [RATE_W-1:0] src_rate_q;
	logic [RATE_W-1:0] tgt_rate_q;
	logic              sixteen_bit_q;
	logic              average_q;
	reg_idx_t          reg_idx;
	logic              wr_en;
	cfg_t              cfg;
	logic              push_valid;
	logic              push_ready;
	sample_t           push_sample;
	logic              pop_valid;
	logic              pop_ready;
	logic [SAMPLE_W-1:0] pop_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rate_q    <= RST_SOURCE_RATE;
			tgt_rate_q    <= RST_TARGET_RATE;
			sixteen_bit_q <= RST_SIXTEEN_BIT;
			average_q     <= RST_AVERAGE;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SOURCE_RATE: src_rate_q    <= pwdata[RATE_W-1:0];
				REG_TARGET_RATE: tgt_rate_q    <= pwdata[RATE_W-1:0];
				REG_SIXTEEN_BIT: sixteen_bit_q <= pwdata[0];
				REG_AVERAGE:     average_q     <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_SOURCE_RATE: prdata = DATA_W'(src_rate_q);
			REG_TARGET_RATE: prdata = DATA_W'(tgt_rate_q);
			REG_SIXTEEN_BIT: prdata = DATA_W'(sixteen_bit_q);
			REG_AVERAGE:     prdata = DATA_W'(average_q);
			default:         prdata = '0;
		endcase
	end

	// a zero rate counts as one
	always_comb begin
		cfg.src_rate    = (src_rate_q == '0) ? RATE_W'(1) : src_rate_q;
		cfg.tgt_rate    = (tgt_rate_q == '0) ? RATE_W'(1) : tgt_rate_q;
		cfg.sixteen_bit = sixteen_bit_q;
		cfg.average     = average_q;
	end

	// front end: accepts frames and converts the sample
	nsrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.frames      (frames),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_sample (push_sample)
	);

	// queue between front and back
	nsrc_queue #(
		.WIDTH (SAMPLE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_sample),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back end: due count and result emission
	nsrc_back #(
		.MAX_OUTPUTS_PER_FRAME (MAX_OUTPUTS_PER_FRAME),
		.INDEX_BITS            (INDEX_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.job_valid  (pop_valid),
		.job_ready  (pop_ready),
		.job_sample (sample_t'(pop_data)),
		.results    (results)
	);

endmodule

`default_nettype wire

// File: sim/nearest_sample_rate_converter_unit_tb.sv
`timescale 1ns / 1ps

module nearest_sample_rate_converter_unit_tb;
	import nsrc_pkg::*;

	localparam int MAX_OUT       = DEF_MAX_OUTPUTS;
	localparam int IDX_W         = DEF_INDEX_BITS;
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int N_DIRECTED    = 6;

	typedef struct packed {
		logic [CHANNEL_W-1:0] a;
		logic [CHANNEL_W-1:0] b;
	} frame_t;

	typedef struct {
		sample_t sample;
		logic    last;
		logic    truncated;
	} out_sample_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	nsrc_frame_if  frames ();
	nsrc_result_if results ();

	nearest_sample_rate_converter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.frames  (frames),
		.results (results)
	);

	// extreme channel words: zero, minus one against zero, both bytes at minimum,
	// full scale, minimum against maximum, byte maximum against byte minimum
	logic [2*CHANNEL_W-1:0] directed_frames [N_DIRECTED] = '{
		32'h0000_0000, 32'hFFFF_0000, 32'h8080_8080,
		32'h7FFF_7FFF, 32'h8000_7FFF, 32'hFF7F_0080
	};

	frame_t      frames_to_send [$];
	out_sample_t due_samples [$];

	// converter state and register copies
	logic [IDX_W-1:0]  frames_seen;
	logic [IDX_W-1:0]  next_output;
	logic [RATE_W-1:0] src_rate;
	logic [RATE_W-1:0] tgt_rate;
	logic              sixteen_mode;
	logic              average_mode;

	int   error_count   = 0;
	logic frame_taken   = 1'b0;
	logic frames_paused = 1'b0;
	int   hold_requests = 0;

	int          burst_left = 0;
	int          gap_left   = 0;
	int          hold_seen  = 0;
	int          hold_left  = 0;
	logic [15:0] rx_cycle   = '0;

	// samples due for one frame, advancing the indices
	function automatic void convert_frame(logic [CHANNEL_W-1:0] a, logic [CHANNEL_W-1:0] b);
		logic [RATE_W-1:0] s;
		logic [RATE_W-1:0] t;
		logic [127:0]      step;
		logic [127:0]      lim;
		logic [IDX_W-1:0]  k;
		int                n;
		int                i;
		int                sa;
		int                sb;
		int                v;
		bit                clipped;
		out_sample_t       r;
		s = (src_rate == '0) ? RATE_W'(1) : src_rate;
		t = (tgt_rate == '0) ? RATE_W'(1) : tgt_rate;
		step = 128'({s, 1'b0});
		lim = 128'(frames_seen) * 128'({t, 1'b0}) + 128'(t);
		k = next_output;
		n = 0;
		clipped = 1'b0;
		while (n < MAX_OUT && 128'(k) * step < lim) begin
			n++;
			k = k + 1'b1;
		end
		// too many due: skip to the first output after this frame
		if (n == MAX_OUT && 128'(k) * step < lim) begin
			clipped = 1'b1;
			k = IDX_W'((lim + step - 1) / step);
		end
		if (sixteen_mode) begin
			sa = $signed(a);
			sb = $signed(b);
			v = average_mode ? (sa + sb) / 2 : sa;
		end else begin
			sa = $signed(a[7:0]);
			sb = $signed(b[7:0]);
			v = average_mode ? (sa + sb) * 128 : sa * 256;
		end
		for (i = 0; i < n; i++) begin
			r.sample = v[SAMPLE_W-1:0];
			r.last = (i == n - 1);
			r.truncated = clipped;
			due_samples.push_back(r);
		end
		next_output = k;
		frames_seen = frames_seen + 1'b1;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SOURCE_RATE: src_rate = value[RATE_W-1:0];
			REG_TARGET_RATE: tgt_rate = value[RATE_W-1:0];
			REG_SIXTEEN_BIT: sixteen_mode = value[0];
			REG_AVERAGE:     average_mode = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [DATA_W-1:0] src, logic [DATA_W-1:0] tgt,
			logic [DATA_W-1:0] six, logic [DATA_W-1:0] avg);
		write_reg(REG_SOURCE_RATE, src);
		write_reg(REG_TARGET_RATE, tgt);
		write_reg(REG_SIXTEEN_BIT, six);
		write_reg(REG_AVERAGE, avg);
	endtask

	task automatic queue_frames(bit with_directed, int count);
		frame_t f;
		if (with_directed) begin
			foreach (directed_frames[i])
				frames_to_send.push_back(frame_t'(directed_frames[i]));
		end
		repeat (count) begin
			f.a = CHANNEL_W'($urandom);
			f.b = CHANNEL_W'($urandom);
			frames_to_send.push_back(f);
		end
	endtask

	// all requests taken and answered, then let silent frames drain
	task automatic wait_idle();
		do @(negedge clk); while (frames_to_send.size() != 0 || due_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// frame driver: bursts with random gaps, request held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			frames.valid <= 1'b0;
		end else if (frames.valid && !frame_taken) begin
			frames.valid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			frames.valid <= 1'b0;
		end else if (frames_to_send.size() == 0 || frames_paused) begin
			frames.valid <= 1'b0;
		end else begin
			frames.valid <= 1'b1;
			frames.channel_a <= frames_to_send[0].a;
			frames.channel_b <= frames_to_send[0].b;
			if (burst_left == 0)
				burst_left = $urandom_range(1, 16);
			burst_left--;
			if (burst_left == 0)
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
	end

	// frame acceptance and prediction
	always @(posedge clk) begin
		frame_taken <= arst_n && frames.valid && frames.ready;
		if (arst_n && frames.valid && frames.ready) begin
			convert_frame(frames.channel_a, frames.channel_b);
			void'(frames_to_send.pop_front());
		end
	end

	// result receiver: long hold on request, quiet stretches, fixed stall pattern
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			results.ready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen++;
			hold_left = HOLD_CYCLES;
			results.ready <= 1'b0;
		end else if (rx_cycle[8:7] == 2'b11) begin
			results.ready <= 1'b1;
		end else begin
			results.ready <= !(rx_cycle % 5 == 2 || rx_cycle % 13 >= 10);
		end
		rx_cycle <= rx_cycle + 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		out_sample_t want;
		if (arst_n && results.valid && results.ready) begin
			if (due_samples.size() == 0) begin
				$error("sample %0d with no frame owing it", results.sample);
				error_count++;
			end else begin
				want = due_samples.pop_front();
				if (results.sample !== want.sample) begin
					$error("sample: expected %0d, got %0d", want.sample, results.sample);
					error_count++;
				end
				if (results.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, results.last);
					error_count++;
				end
				if (results.truncated !== want.truncated) begin
					$error("truncated: expected %0b, got %0b", want.truncated,
						results.truncated);
					error_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		frames.valid = 1'b0;
		frames.channel_a = '0;
		frames.channel_b = '0;
		results.ready = 1'b0;
		frames_seen = '0;
		next_output = '0;
		src_rate = RST_SOURCE_RATE;
		tgt_rate = RST_TARGET_RATE;
		sixteen_mode = RST_SIXTEEN_BIT;
		average_mode = RST_AVERAGE;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// register defaults, sparse output
		queue_frames(1'b1, 20);
		wait_idle();

		// eight per frame, averaged 16-bit
		set_config(1000, 8000, 1, 1);
		queue_frames(1'b1, 30);
		wait_idle();

		// nine due per frame, always truncated, 8-bit
		set_config(1000, 9000, 0, 0);
		queue_frames(1'b1, 30);
		wait_idle();

		// uneven ratio, averaged 8-bit
		set_config(3, 5, 0, 1);
		queue_frames(1'b1, 30);
		wait_idle();

		// rate extremes both ways
		set_config(262143, 1, 1, 1);
		queue_frames(1'b0, 15);
		wait_idle();
		set_config(1, 262143, 0, 0);
		queue_frames(1'b0, 15);
		wait_idle();

		// zero rates read as one, upper data bits ignored
		set_config(32'hFFFC_0000, 32'hFFFC_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		queue_frames(1'b0, 30);
		wait_idle();

		// receiver hold fills the block, then sender waits for all results
		set_config(48000, 44100, 1, 0);
		queue_frames(1'b0, 40);
		hold_requests <= hold_requests + 1;
		do @(negedge clk); while (frames_to_send.size() > 20);
		frames_paused <= 1'b1;
		do @(negedge clk); while (due_samples.size() != 0);
		frames_paused <= 1'b0;
		wait_idle();

		// random settings
		repeat (3) begin
			set_config($urandom_range(1, 262143), $urandom_range(1, 262143),
				$urandom_range(0, 1), $urandom_range(0, 1));
			queue_frames(1'b0, 12);
			wait_idle();
		end

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/core/nsrc_pkg.sv
rtl/core/nsrc_if.sv
rtl/core/nsrc_front.sv
rtl/core/nsrc_queue.sv
rtl/core/nsrc_div.sv
rtl/core/nsrc_back.sv
rtl/core/nearest_sample_rate_converter_unit.sv
sim/nearest_sample_rate_converter_unit_tb.sv
